@@ rtl/pnc_pkg.sv @@
package pnc_pkg;

  localparam int SUM_W   = 28;
  localparam int SQ_W    = 40;
  localparam int CNT_W   = 16;
  localparam int ADC_W   = 12;
  localparam int CPP_W   = 12;
  localparam int CH_W    = 11;
  localparam int PL_W    = 2;
  localparam int CMD_W   = 2;
  localparam int THR_W   = 13;

  localparam logic [CMD_W-1:0] CMD_ACC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [PL_W-1:0]  plane;
    logic [CH_W-1:0]  channel;
    logic [ADC_W-1:0] adc_value;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [ADC_W-1:0]  pedestal;
    logic [ADC_W-1:0]  noise;
    logic [THR_W-1:0]  threshold;
    logic [CNT_W-1:0]  sample_count;
  } out_item_t;

  // classified operation from front to back; address is 17 bits wide max
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             bad;
    logic [16:0]      addr;
    logic [ADC_W-1:0] adc_value;
  } op_t;

endpackage

@@ rtl/pnc_if.sv @@
interface pnc_in_if;
  logic             valid;
  logic             ready;
  pnc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pnc_out_if;
  logic              valid;
  logic              ready;
  pnc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/pnc_ram.sv @@
module pnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/pnc_front.sv @@
module pnc_front #(
  parameter int STORE_DEPTH = 4096,
  parameter int PLANES = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [pnc_pkg::CPP_W-1:0] cfg_data,
  pnc_in_if.sink                  in_ch,
  output logic                    q_valid,
  input  logic                    q_ready,
  output pnc_pkg::op_t            q_op
);
  logic [pnc_pkg::CPP_W-1:0] cpp;
  logic [16:0] prod;
  logic [17:0] addr_full;
  logic        bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      cpp <= 12'd1280;
    end else if (cfg_we) begin
      cpp <= cfg_data;
    end
  end

  // plane is 2 bits so the product is a small multiply
  assign prod = 17'(in_ch.data.plane) * 17'(cpp);
  assign addr_full = 18'(prod) + 18'(in_ch.data.channel);
  assign bad = (32'(in_ch.data.plane) >= 32'(PLANES)) ||
               (32'(addr_full) >= 32'(STORE_DEPTH));

  // two-entry queue toward the back end
  pnc_pkg::op_t buf0, buf1;
  logic [1:0] fill;
  logic push, pop;

  assign in_ch.ready = (fill != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign pop  = q_valid && q_ready;
  assign q_valid = (fill != 2'd0);
  assign q_op = buf0;

  pnc_pkg::op_t new_op;
  always_comb begin
    new_op.command   = in_ch.data.command;
    new_op.bad       = bad;
    new_op.addr      = addr_full[16:0];
    new_op.adc_value = in_ch.data.adc_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + 2'(push) - 2'(pop);
    end
    case ({push, pop})
      2'b10: begin
        if (fill == 2'd0) buf0 <= new_op;
        else buf1 <= new_op;
      end
      2'b01: buf0 <= buf1;
      2'b11: begin
        if (fill == 2'd1) buf0 <= new_op;
        else begin
          buf0 <= buf1;
          buf1 <= new_op;
        end
      end
      default: ;
    endcase
  end
endmodule

@@ rtl/pnc_math.sv @@
// sequential divide and square root for read commands
module pnc_math (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pnc_pkg::SUM_W-1:0] sum,
  input  logic [pnc_pkg::SQ_W-1:0]  sq,
  input  logic [pnc_pkg::CNT_W-1:0] cnt,
  output logic                      done,
  output logic [pnc_pkg::ADC_W-1:0] ped,
  output logic [pnc_pkg::ADC_W-1:0] noi
);
  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_DIV1 = 3'd1;
  localparam logic [2:0] M_DIV2 = 3'd2;
  localparam logic [2:0] M_PREP = 3'd3;
  localparam logic [2:0] M_SQRT = 3'd4;
  localparam logic [2:0] M_DONE = 3'd5;

  logic [2:0]  st;
  logic [5:0]  k;
  logic [15:0] n;
  logic [39:0] num, quo, quo_next;
  logic [39:0] rem, rem_next;
  logic [27:0] ped_q;
  logic [1:0]  ratio;
  logic [41:0] v, res, bitv;
  logic [40:0] rem_sh;
  logic [23:0] p2;
  logic        q_bit;
  logic [39:0] diff;

  // restoring division, one quotient bit a cycle
  assign rem_sh = {rem, num[39]};
  assign q_bit = (rem_sh >= 41'(n));
  assign rem_next = q_bit ? 40'(rem_sh - 41'(n)) : rem_sh[39:0];
  assign quo_next = {quo[38:0], q_bit};
  // p2 uses the clamped pedestal
  assign p2 = 24'(ped) * 24'(ped);
  assign diff = (quo > 40'(p2)) ? quo - 40'(p2) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= M_IDLE;
      done <= 1'b0;
    end else begin
      done <= (st == M_DONE);
      case (st)
        M_IDLE: begin
          if (start) begin
            n <= cnt;
            num <= 40'(sum);
            rem <= '0;
            k <= 6'd0;
            st <= M_DIV1;
          end
        end
        M_DIV1, M_DIV2: begin
          quo <= quo_next;
          if (k == 6'd39) begin
            k <= 6'd0;
            rem <= '0;
            if (st == M_DIV1) begin
              ped_q <= quo_next[27:0];
              num <= sq;
              st <= M_DIV2;
            end else begin
              st <= M_PREP;
            end
          end else begin
            k <= k + 6'd1;
            rem <= rem_next;
            num <= {num[38:0], 1'b0};
          end
        end
        M_PREP: begin
          ped <= (ped_q > 28'd4095) ? 12'd4095 : ped_q[11:0];
          ratio <= (n == 16'd2) ? 2'd2 : 2'd1;
          st <= M_SQRT;
          k <= 6'd0;
        end
        M_SQRT: begin
          if (k == 6'd0) begin
            v <= (ratio == 2'd2) ? {1'b0, diff, 1'b0} : {2'b00, diff};
            res <= '0;
            bitv <= 42'd1 << 40;
            k <= 6'd1;
          end else begin
            if (v >= res + bitv) begin
              v <= v - (res + bitv);
              res <= (res >> 1) + bitv;
            end else begin
              res <= res >> 1;
            end
            bitv <= bitv >> 2;
            if (k == 6'd21) st <= M_DONE;
            k <= k + 6'd1;
          end
        end
        M_DONE: begin
          noi <= (res > 42'd4095) ? 12'd4095 : res[11:0];
          st <= M_IDLE;
        end
        default: st <= M_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/pnc_back.sv @@
module pnc_back #(
  parameter int STORE_DEPTH = 4096
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  pnc_pkg::op_t  q_op,
  pnc_out_if.source     out_ch
);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [2:0] B_CLR  = 3'd0;
  localparam logic [2:0] B_IDLE = 3'd1;
  localparam logic [2:0] B_RD   = 3'd2;
  localparam logic [2:0] B_EXEC = 3'd3;
  localparam logic [2:0] B_MATH = 3'd4;
  localparam logic [2:0] B_OUT  = 3'd5;

  logic [2:0] st;
  logic [AW:0] clr_cnt;
  pnc_pkg::op_t op;
  logic we;
  logic [AW-1:0] waddr;
  logic [pnc_pkg::SUM_W-1:0] sum_w, sum_r;
  logic [pnc_pkg::SQ_W-1:0]  sq_w, sq_r;
  logic [pnc_pkg::CNT_W-1:0] cnt_w, cnt_r, cnt_inc;
  logic m_start, m_done;
  logic [11:0] m_ped, m_noi;
  pnc_pkg::out_item_t res;

  pnc_ram #(.WIDTH(pnc_pkg::SUM_W), .DEPTH(STORE_DEPTH)) u_sum (
    .clk, .we, .waddr, .wdata(sum_w), .raddr(op.addr[AW-1:0]), .rdata(sum_r));
  pnc_ram #(.WIDTH(pnc_pkg::SQ_W), .DEPTH(STORE_DEPTH)) u_sq (
    .clk, .we, .waddr, .wdata(sq_w), .raddr(op.addr[AW-1:0]), .rdata(sq_r));
  pnc_ram #(.WIDTH(pnc_pkg::CNT_W), .DEPTH(STORE_DEPTH)) u_cnt (
    .clk, .we, .waddr, .wdata(cnt_w), .raddr(op.addr[AW-1:0]), .rdata(cnt_r));

  pnc_math u_math (
    .clk, .rst, .start(m_start), .sum(sum_r), .sq(sq_r), .cnt(cnt_r),
    .done(m_done), .ped(m_ped), .noi(m_noi));

  logic [23:0] sqr;
  assign sqr = 24'(op.adc_value) * 24'(op.adc_value);
  assign cnt_inc = (cnt_r != pnc_pkg::COUNT_MAX) ? cnt_r + 16'd1 : cnt_r;

  assign q_ready = (st == B_IDLE);
  assign m_start = (st == B_EXEC) && (op.command == pnc_pkg::CMD_READ) &&
                   (cnt_r > 16'd1);
  assign out_ch.valid = (st == B_OUT);
  assign out_ch.data = res;

  always_comb begin
    we = 1'b0;
    waddr = op.addr[AW-1:0];
    sum_w = '0;
    sq_w = '0;
    cnt_w = '0;
    if (st == B_CLR) begin
      we = 1'b1;
      waddr = clr_cnt[AW-1:0];
    end else if (st == B_EXEC) begin
      if (op.command == pnc_pkg::CMD_ACC && cnt_r != pnc_pkg::COUNT_MAX) begin
        we = 1'b1;
        sum_w = sum_r + 28'(op.adc_value);
        sq_w = sq_r + 40'(sqr);
        cnt_w = cnt_r + 16'd1;
      end else if (op.command == pnc_pkg::CMD_CLEAR) begin
        we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= B_CLR;
      clr_cnt <= '0;
    end else begin
      case (st)
        B_CLR: begin
          clr_cnt <= clr_cnt + (AW+1)'(1);
          if (clr_cnt == (AW+1)'(STORE_DEPTH - 1)) st <= B_IDLE;
        end
        B_IDLE: begin
          if (q_valid) begin
            op <= q_op;
            if (q_op.bad || q_op.command == pnc_pkg::CMD_NONE) begin
              res <= '{status: q_op.bad && (q_op.command != pnc_pkg::CMD_NONE),
                       pedestal: 12'd0, noise: 12'd0, threshold: 13'd0,
                       sample_count: 16'd0};
              st <= B_OUT;
            end else begin
              st <= B_RD;
            end
          end
        end
        B_RD: st <= B_EXEC;
        B_EXEC: begin
          res <= '{status: 1'b0, pedestal: 12'd0, noise: 12'd0, threshold: 13'd0,
                   sample_count: (op.command == pnc_pkg::CMD_ACC) ? cnt_inc :
                                 (op.command == pnc_pkg::CMD_READ) ? cnt_r : 16'd0};
          case (op.command)
            pnc_pkg::CMD_READ: st <= (cnt_r > 16'd1) ? B_MATH : B_OUT;
            default: st <= B_OUT;
          endcase
        end
        B_MATH: begin
          if (m_done) begin
            res.pedestal <= m_ped;
            res.noise <= m_noi;
            res.threshold <= 13'(m_ped) + 13'(m_noi);
            st <= B_OUT;
          end
        end
        B_OUT: begin
          if (out_ch.ready) st <= B_IDLE;
        end
        default: st <= B_IDLE;
      endcase
    end
  end
endmodule

@@ rtl/pedestal_noise_calibrator_unit.sv @@
// pedestal and noise calibration store for strip channels
// in_ch carries command, plane, channel, adc_value; out_ch returns status,
// pedestal, noise, threshold and sample_count, one transaction per input
// transaction, in order. cfg_we/cfg_data write channels_per_plane (idle only).
// the front classifies the entry address and queues up to two transactions;
// the back does a read-modify-write of the three entry memories.
// the back end is occupied from input to result acceptance: accumulate, clear
// and reads of fewer than two samples pass the read, execute and output states,
// out-of-range and unused commands go straight to the output state.
// reads of an entry with more than one sample run two 40-step serial
// divides and then a serial square root before the output state.
// after reset the back end clears all STORE_DEPTH entries, one a cycle,
// before it takes the first transaction; the front queue still fills.
// when the receiver stalls the result waits in the output register and the
// queue fills, then in_ch.ready drops.
module pedestal_noise_calibrator_unit #(
  parameter int STORE_DEPTH = 4096,
  parameter int PLANES = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [pnc_pkg::CPP_W-1:0] cfg_data,
  pnc_in_if.sink                    in_ch,
  pnc_out_if.source                 out_ch
);
  logic q_valid, q_ready;
  pnc_pkg::op_t q_op;

  pnc_front #(.STORE_DEPTH(STORE_DEPTH), .PLANES(PLANES)) u_front (
    .clk, .rst, .cfg_we, .cfg_data, .in_ch, .q_valid, .q_ready, .q_op);

  pnc_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_op, .out_ch);
endmodule

@@ rtl/pnc_checker.sv @@
module pnc_prop_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input pnc_pkg::out_item_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed under stall");
  a_thr: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.threshold == 13'(out_data.pedestal) + 13'(out_data.noise))
    else $error("threshold mismatch");
  a_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.sample_count == '0)
    else $error("flagged result carries count");
  a_few: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.sample_count < 16'd2 |-> out_data.noise == '0)
    else $error("noise without samples");
endmodule

bind pedestal_noise_calibrator_unit pnc_prop_checker u_chk (
  .clk, .rst,
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
